### hdl/multi_channel_servo_pulse_generator_defines.svh
// ----------------------------------------------------------------------------
// Servo pulse generator assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SERVO_PULSE_GENERATOR_DEFINES_SVH
`define MULTI_CHANNEL_SERVO_PULSE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define MCSP_ASSERT_SAME(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCSP_ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`else

`define MCSP_ASSERT_SAME(lbl, clk, rst_n, ant, con, msg)
`define MCSP_ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg)

`endif

`endif

### hdl/mcsp_pkg.sv
// ----------------------------------------------------------------------------
// Servo pulse generator package
// Item types, codes and fixed constants shared by the generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsp_pkg;

    // Item kinds carried on tuser.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_FRAME_TICKS = 2'd0;
    localparam logic [1:0] REG_MIN_PULSE   = 2'd1;
    localparam logic [1:0] REG_MAX_PULSE   = 2'd2;

    localparam logic [15:0] FRAME_TICKS_RESET = 16'd20000;
    localparam logic [11:0] MIN_PULSE_RESET   = 12'd350;
    localparam logic [11:0] MAX_PULSE_RESET   = 12'd2450;
    localparam logic [11:0] WIDTH_RESET       = 12'd1000;

    // Position range.
    localparam logic signed [11:0] POS_MIN    = -12'sd1000;
    localparam logic signed [11:0] POS_MAX    = 12'sd1000;
    localparam logic signed [12:0] POS_OFFSET = 13'sd1000;
    localparam logic [10:0]        POS_SPAN   = 11'd2000;

    // Division by 2000 is a shift by 4 followed by an exact reciprocal
    // multiply for division by 125 over a 19-bit dividend.
    localparam int          PRE_SHIFT   = 4;
    localparam int          RECIP_SHIFT = 26;
    localparam logic [19:0] RECIP_125   = 20'd536871;

    typedef struct packed {
        logic        kind;
        logic [2:0]  ch;
        logic [10:0] offs;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  ch;
        logic        neg;
        logic [18:0] mag;
    } prod_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  ch;
        logic        neg;
        logic [11:0] quot;
    } map_t;

endpackage

`default_nettype wire

### hdl/multi_channel_servo_pulse_generator.sv
// ----------------------------------------------------------------------------
// Multi-channel servo pulse generator
// Frame counter and per-channel pulse widths driven by tick and command items.
// ----------------------------------------------------------------------------
// Usage:
// Each slave transaction is either a one-microsecond tick (tuser low) or a
// position command (tuser high) that sets one channel's pulse width from a
// position in -1000..1000. Every transaction yields exactly one master
// transaction: the pin levels of all channels and, for a tick, a flag on
// tuser that marks the first tick of a frame.
// A transaction is accepted every cycle unless the pipeline is stalled. The
// accepting edge loads the first mapping stage, the transaction then moves
// through the second and third stages, and the output register load applies
// the state update. The configuration channel is always ready; it is to be
// written by the user only while the block is idle; the block does not
// enforce this. Reset restores the register defaults, clears the frame
// counter and sets every width to 1000 microseconds.
// When the receiver stalls, the output register holds its transaction, the
// mapping stages fill up, and slave tready drops once all of them are full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_channel_servo_pulse_generator_defines.svh"

module multi_channel_servo_pulse_generator #(
    parameter int CHANNELS = 3
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [2:0] channel, [14:3] position, [15] zero
    input  wire         s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [2:0] pins, [7:3] zero
    output logic        m_tuser,   // [0] frame_start
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    localparam int PIN_COUNT = (CHANNELS < 3) ? CHANNELS : 3;

    logic [15:0] frame_ticks_reg;
    logic [11:0] min_pulse_reg;
    logic [11:0] max_pulse_reg;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [11:0] widths_reg [CHANNELS];
    logic [11:0] widths_next [CHANNELS];
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    logic           map_valid;
    logic           out_ld;
    mcsp_pkg::map_t map_item;

    logic        upd;
    logic        is_cmd;
    logic [12:0] quot_ext;
    logic [12:0] new_w_full;
    logic [11:0] new_w;
    logic [2:0]  pins_c;
    logic [16:0] tick_inc;
    logic        wrap;

    assign out_ld    = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    mcsp_pos_map #(
        .CHANNELS (CHANNELS)
    ) u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_channel  (s_tdata[2:0]),
        .in_position ($signed(s_tdata[14:3])),
        .min_pulse   (min_pulse_reg),
        .max_pulse   (max_pulse_reg),
        .out_valid   (map_valid),
        .out_ready   (out_ld),
        .out_item    (map_item)
    );

    always_comb
    begin
        upd        = map_valid && out_ld;
        is_cmd     = map_item.kind == mcsp_pkg::KIND_CMD;
        quot_ext   = {1'b0, map_item.quot};
        new_w_full = {1'b0, min_pulse_reg} + (map_item.neg ? 13'(-quot_ext) : quot_ext);
        new_w      = new_w_full[11:0];

        // A command's own result already sees its new width.
        pins_c = '0;
        for (int n = 0; n < PIN_COUNT; n++)
        begin
            if (is_cmd && map_item.ch == 3'(n))
            begin
                pins_c[n] = tick_count_reg >= {4'b0, new_w};
            end
            else
            begin
                pins_c[n] = tick_count_reg >= {4'b0, widths_reg[n]};
            end
        end

        tick_inc = {1'b0, tick_count_reg} + 17'd1;
        wrap     = tick_inc >= {1'b0, frame_ticks_reg};

        widths_next     = widths_reg;
        tick_count_next = tick_count_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tvalid_next   = out_ld ? map_valid : m_tvalid_reg;
        if (upd)
        begin
            m_tdata_next = 8'(pins_c);
            if (is_cmd)
            begin
                m_tuser_next = 1'b0;
                for (int n = 0; n < CHANNELS; n++)
                begin
                    if (map_item.ch == 3'(n))
                    begin
                        widths_next[n] = new_w;
                    end
                end
            end
            else
            begin
                m_tuser_next    = tick_count_reg == '0;
                tick_count_next = wrap ? '0 : tick_inc[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ticks_reg <= mcsp_pkg::FRAME_TICKS_RESET;
            min_pulse_reg   <= mcsp_pkg::MIN_PULSE_RESET;
            max_pulse_reg   <= mcsp_pkg::MAX_PULSE_RESET;
            tick_count_reg  <= '0;
            for (int n = 0; n < CHANNELS; n++)
            begin
                widths_reg[n] <= mcsp_pkg::WIDTH_RESET;
            end
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mcsp_pkg::REG_FRAME_TICKS: frame_ticks_reg <= cfg_data;
                    mcsp_pkg::REG_MIN_PULSE:   min_pulse_reg   <= cfg_data[11:0];
                    mcsp_pkg::REG_MAX_PULSE:   max_pulse_reg   <= cfg_data[11:0];
                    default:                   ;
                endcase
            end
            tick_count_reg <= tick_count_next;
            widths_reg     <= widths_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `MCSP_ASSERT_NEXT(a_stall_holds_count, clk, rst_n,
        m_tvalid_reg && !m_tready, $stable(tick_count_reg),
        "frame counter moved while the output was stalled")

    `MCSP_ASSERT_NEXT(a_cmd_holds_count, clk, rst_n,
        upd && is_cmd, $stable(tick_count_reg),
        "position command advanced the frame counter")

    `MCSP_ASSERT_NEXT(a_wrap_to_zero, clk, rst_n,
        upd && !is_cmd && wrap, tick_count_reg == '0,
        "frame counter did not wrap at the end of the frame")

    `MCSP_ASSERT_SAME(a_start_only_at_zero, clk, rst_n,
        upd && !is_cmd && tick_count_reg != '0, m_tuser_next == 1'b0,
        "frame start flagged away from the first tick")

endmodule

`default_nettype wire

### hdl/mcsp_pos_map.sv
// ----------------------------------------------------------------------------
// Position mapping pipeline
// Clamps a transaction's channel and position and computes the signed
// quotient (max - min) * (pos + 1000) / 2000 over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsp_pos_map #(
    parameter int CHANNELS = 3
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 in_kind,
    input  wire  [2:0]          in_channel,
    input  wire  signed [11:0]  in_position,
    input  wire  [11:0]         min_pulse,
    input  wire  [11:0]         max_pulse,
    output logic                out_valid,
    input  wire                 out_ready,
    output mcsp_pkg::map_t      out_item
);

    mcsp_pkg::item_t s1_reg, s1_next;
    mcsp_pkg::prod_t s2_reg, s2_next;
    mcsp_pkg::map_t  s3_reg, s3_next;
    logic            v1_reg, v2_reg, v3_reg;
    logic            ld1, ld2, ld3;

    logic signed [12:0] pos_ext;
    logic signed [12:0] span_diff;
    logic signed [24:0] prod;
    logic        [24:0] prod_abs;
    logic        [38:0] recip_prod;

    assign ld3      = !v3_reg || out_ready;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // Stage 1: clamp channel and position.
    always_comb
    begin
        pos_ext      = $signed({in_position[11], in_position}) + mcsp_pkg::POS_OFFSET;
        s1_next.kind = in_kind;
        if ({1'b0, in_channel} >= 4'(CHANNELS))
        begin
            s1_next.ch = 3'(CHANNELS - 1);
        end
        else
        begin
            s1_next.ch = in_channel;
        end
        if (in_position < mcsp_pkg::POS_MIN)
        begin
            s1_next.offs = '0;
        end
        else if (in_position > mcsp_pkg::POS_MAX)
        begin
            s1_next.offs = mcsp_pkg::POS_SPAN;
        end
        else
        begin
            s1_next.offs = pos_ext[10:0];
        end
    end

    // Stage 2: signed product of the span and the offset position.
    always_comb
    begin
        span_diff    = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
        prod         = span_diff * $signed({1'b0, s1_reg.offs});
        prod_abs     = prod[24] ? 25'(-prod) : 25'(prod);
        s2_next.kind = s1_reg.kind;
        s2_next.ch   = s1_reg.ch;
        s2_next.neg  = prod[24];
        s2_next.mag  = prod_abs[22:mcsp_pkg::PRE_SHIFT];
    end

    // Stage 3: magnitude divided by 125 through the reciprocal.
    always_comb
    begin
        recip_prod   = 39'(s2_reg.mag) * 39'(mcsp_pkg::RECIP_125);
        s3_next.kind = s2_reg.kind;
        s3_next.ch   = s2_reg.ch;
        s3_next.neg  = s2_reg.neg;
        s3_next.quot = recip_prod[mcsp_pkg::RECIP_SHIFT +: 12];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_reg <= s1_next;
        end
        if (ld2)
        begin
            s2_reg <= s2_next;
        end
        if (ld3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = s3_reg;

endmodule

`default_nettype wire
